// ----- rtl/core/wqpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wqpm_pkg
// Shared codes, widths and the result type of the wait queue pool manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wqpm_pkg;

    localparam int OP_W    = 3;
    localparam int QID_W   = 4;
    localparam int PID_W   = 8;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_INIT     = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_WAKE_ONE = 3'd3;
    localparam logic [OP_W-1:0] OP_WAKE_ALL = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_MEM  = 2'd2;

    localparam logic [PID_W-1:0] PID_NONE = 8'd0;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              woken_valid;
        logic [PID_W-1:0]  woken_proc;
        logic              last;
    } t_rsp;

endpackage

`default_nettype wire

// ----- rtl/core/wqpm_if.sv -----
// ----------------------------------------------------------------------------
// wqpm_if
// Request and response channels of the wait queue pool manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wqpm_req_if;
    import wqpm_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [QID_W-1:0]   queue_id;
    logic [PID_W-1:0]   proc_id;
    modport source (output valid, output op, output queue_id, output proc_id, input ready);
    modport sink   (input valid, input op, input queue_id, input proc_id, output ready);
endinterface

interface wqpm_rsp_if;
    import wqpm_pkg::*;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic               woken_valid;
    logic [PID_W-1:0]   woken_proc;
    logic               last;
    modport source (output valid, output status, output woken_valid, output woken_proc,
                    output last, input ready);
    modport sink   (input valid, input status, input woken_valid, input woken_proc,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wait_queue_pool_manager.sv -----
// ----------------------------------------------------------------------------
// wait_queue_pool_manager
// Pool of wait entries shared by several wait queues, kept in two memories.
// ----------------------------------------------------------------------------
// One item is worked at a time by a sequencer around an entry memory and a
// queue head memory, both with a registered read port. Init and rejected
// items go straight to the result; add walks the queue and then scans the
// pool for the lowest free entry; remove scans the whole pool and unlinks
// each match by walking its queue. A wake runs one remove for each woken
// process. After reset a clearing pass over every entry and queue head runs
// with ready low. The next item is accepted while the last result still
// waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module wait_queue_pool_manager #(
    parameter int POOL_ENTRIES = 32,
    parameter int QUEUE_COUNT  = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wqpm_req_if.sink   i_req,
    wqpm_rsp_if.source o_rsp
);
    import wqpm_pkg::*;

    localparam int LW   = $clog2(POOL_ENTRIES + 1);
    localparam int IW   = $clog2(POOL_ENTRIES);
    localparam int QW   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int QCW  = $clog2(QUEUE_COUNT + 1);
    localparam int QX   = (QCW > QID_W) ? QCW : QID_W;
    localparam int PQ   = (POOL_ENTRIES > QUEUE_COUNT) ? POOL_ENTRIES : QUEUE_COUNT;
    localparam int CW   = $clog2(PQ + 1);
    localparam logic [LW-1:0] LNULL = LW'(POOL_ENTRIES);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DISP   = 5'd2;
    localparam logic [4:0] S_EMIT   = 5'd3;
    localparam logic [4:0] S_AD_HW  = 5'd4;
    localparam logic [4:0] S_AD_WK  = 5'd5;
    localparam logic [4:0] S_AD_WD  = 5'd6;
    localparam logic [4:0] S_AD_SC  = 5'd7;
    localparam logic [4:0] S_AD_SD  = 5'd8;
    localparam logic [4:0] S_RM_SC  = 5'd9;
    localparam logic [4:0] S_RM_SD  = 5'd10;
    localparam logic [4:0] S_FE_HD  = 5'd11;
    localparam logic [4:0] S_FE_HW  = 5'd12;
    localparam logic [4:0] S_FE_WK  = 5'd13;
    localparam logic [4:0] S_FE_WD  = 5'd14;
    localparam logic [4:0] S_FE_UL  = 5'd15;
    localparam logic [4:0] S_FE_CLR = 5'd16;
    localparam logic [4:0] S_WK_HW  = 5'd17;
    localparam logic [4:0] S_WK_EN  = 5'd18;
    localparam logic [4:0] S_WK_ED  = 5'd19;

    localparam logic RET_RM   = 1'b0;
    localparam logic RET_WAKE = 1'b1;

    typedef struct packed {
        logic [PID_W-1:0] proc;
        logic [QID_W-1:0] queue;
        logic [LW-1:0]    next;
    } t_entry;

    localparam t_entry ENTRY_FREE = '{proc: PID_NONE, queue: '0, next: LNULL};

    t_entry        mem_entry [POOL_ENTRIES];
    logic [LW-1:0] mem_head  [QUEUE_COUNT];

    t_entry        r_e_rd;
    logic [LW-1:0] r_h_rd;

    logic          w_e_we;
    logic [IW-1:0] w_e_wa;
    t_entry        w_e_wd;
    logic [IW-1:0] w_e_ra;
    logic          w_h_we;
    logic [QW-1:0] w_h_wa;
    logic [LW-1:0] w_h_wd;
    logic [QW-1:0] w_h_ra;

    logic [4:0]       r_state, n_state, r_nxt, n_nxt;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [OP_W-1:0]  r_op, n_op;
    logic [QID_W-1:0] r_q, n_q;
    logic [PID_W-1:0] r_p, n_p, r_rp, n_rp, r_wp, n_wp;
    logic [LW-1:0]    r_head, n_head, r_cur, n_cur, r_prev, n_prev;
    logic [LW-1:0]    r_steps, n_steps, r_idx, n_idx, r_fidx, n_fidx, r_fn, n_fn;
    logic [LW-1:0]    r_n, n_n;
    logic [QID_W-1:0] r_fq, n_fq;
    t_entry           r_prev_d, n_prev_d;
    logic             r_ret, n_ret, r_have, n_have;
    t_rsp             r_res, n_res, r_o, n_o;
    logic             r_ov, n_ov;

    logic [QX-1:0]    w_qx, w_fqx;
    logic [QW-1:0]    w_qa, w_fqa;
    logic             w_q_ok, w_fq_ok, w_last;

    assign w_qx    = QX'(r_q);
    assign w_fqx   = QX'(r_fq);
    assign w_qa    = w_qx[QW-1:0];
    assign w_fqa   = w_fqx[QW-1:0];
    assign w_q_ok  = (w_qx < QX'(QUEUE_COUNT));
    assign w_fq_ok = (w_fqx < QX'(QUEUE_COUNT));
    assign w_last  = (r_h_rd >= LNULL) || (r_n == LW'(POOL_ENTRIES - 1))
                     || (r_op == OP_WAKE_ONE);

    always_ff @(posedge i_clk) begin
        if (w_e_we) begin
            mem_entry[w_e_wa] <= w_e_wd;
        end
        r_e_rd <= mem_entry[w_e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_h_we) begin
            mem_head[w_h_wa] <= w_h_wd;
        end
        r_h_rd <= mem_head[w_h_ra];
    end

    always_comb begin
        n_state  = r_state;
        n_nxt    = r_nxt;
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_q      = r_q;
        n_p      = r_p;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_head   = r_head;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_prev_d = r_prev_d;
        n_steps  = r_steps;
        n_idx    = r_idx;
        n_fidx   = r_fidx;
        n_fq     = r_fq;
        n_fn     = r_fn;
        n_n      = r_n;
        n_ret    = r_ret;
        n_have   = r_have;
        n_res    = r_res;
        n_o      = r_o;
        n_ov     = r_ov && !o_rsp.ready;
        w_e_we   = 1'b0;
        w_e_wa   = r_idx[IW-1:0];
        w_e_wd   = ENTRY_FREE;
        w_e_ra   = r_cur[IW-1:0];
        w_h_we   = 1'b0;
        w_h_wa   = w_qa;
        w_h_wd   = LNULL;
        w_h_ra   = w_qa;

        unique case (r_state)
            S_CLR: begin
                w_e_we = (r_cnt < CW'(POOL_ENTRIES));
                w_e_wa = r_cnt[IW-1:0];
                w_h_we = (r_cnt < CW'(QUEUE_COUNT));
                w_h_wa = r_cnt[QW-1:0];
                if (r_cnt == CW'(PQ - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.op;
                    n_q     = i_req.queue_id;
                    n_p     = i_req.proc_id;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_res   = '{status: ST_OK, woken_valid: 1'b0, woken_proc: PID_NONE,
                            last: 1'b1};
                n_nxt   = S_IDLE;
                n_state = S_EMIT;
                if (r_op > OP_WAKE_ALL || (r_op != OP_REMOVE && !w_q_ok)) begin
                    n_res.status = ST_INVALID;
                end else if (r_op == OP_INIT) begin
                    w_h_we = 1'b1;
                end else if (r_op == OP_ADD) begin
                    if (r_p == PID_NONE) begin
                        n_res.status = ST_INVALID;
                    end else begin
                        n_state = S_AD_HW;
                    end
                end else if (r_op == OP_REMOVE) begin
                    if (r_p != PID_NONE) begin
                        n_rp    = r_p;
                        n_idx   = '0;
                        n_state = S_RM_SC;
                    end
                end else begin
                    n_have  = 1'b0;
                    n_n     = '0;
                    n_state = S_WK_HW;
                end
            end
            S_EMIT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_o     = r_res;
                    n_state = r_nxt;
                end
            end
            S_AD_HW: begin
                n_head  = r_h_rd;
                n_cur   = r_h_rd;
                n_steps = '0;
                n_state = S_AD_WK;
            end
            S_AD_WK: begin
                if (r_cur >= LNULL || r_steps == LW'(POOL_ENTRIES)) begin
                    n_idx   = '0;
                    n_state = S_AD_SC;
                end else begin
                    n_state = S_AD_WD;
                end
            end
            S_AD_WD: begin
                if (r_e_rd.proc == r_p) begin
                    n_res   = '{status: ST_OK, woken_valid: 1'b0, woken_proc: PID_NONE,
                                last: 1'b1};
                    n_nxt   = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    n_cur   = r_e_rd.next;
                    n_steps = r_steps + 1'b1;
                    n_state = S_AD_WK;
                end
            end
            S_AD_SC: begin
                w_e_ra = r_idx[IW-1:0];
                if (r_idx == LW'(POOL_ENTRIES)) begin
                    n_res   = '{status: ST_NO_MEM, woken_valid: 1'b0, woken_proc: PID_NONE,
                                last: 1'b1};
                    n_nxt   = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_AD_SD;
                end
            end
            S_AD_SD: begin
                if (r_e_rd.proc == PID_NONE) begin
                    w_e_we  = 1'b1;
                    w_e_wd  = '{proc: r_p, queue: r_q, next: r_head};
                    w_h_we  = 1'b1;
                    w_h_wd  = r_idx;
                    n_res   = '{status: ST_OK, woken_valid: 1'b0, woken_proc: PID_NONE,
                                last: 1'b1};
                    n_nxt   = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_AD_SC;
                end
            end
            S_RM_SC: begin
                w_e_ra = r_idx[IW-1:0];
                if (r_idx == LW'(POOL_ENTRIES)) begin
                    if (r_op == OP_REMOVE) begin
                        n_res   = '{status: ST_OK, woken_valid: 1'b0, woken_proc: PID_NONE,
                                    last: 1'b1};
                        n_nxt   = S_IDLE;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_WK_HW;
                    end
                end else begin
                    n_state = S_RM_SD;
                end
            end
            S_RM_SD: begin
                if (r_e_rd.proc == r_rp) begin
                    n_fidx  = r_idx;
                    n_fq    = r_e_rd.queue;
                    n_fn    = r_e_rd.next;
                    n_ret   = RET_RM;
                    n_state = S_FE_HD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RM_SC;
                end
            end
            S_FE_HD: begin
                w_h_ra  = w_fqa;
                n_prev  = LNULL;
                n_steps = '0;
                n_state = w_fq_ok ? S_FE_HW : S_FE_CLR;
            end
            S_FE_HW: begin
                n_cur   = r_h_rd;
                n_state = S_FE_WK;
            end
            S_FE_WK: begin
                if (r_cur >= LNULL || r_steps == LW'(POOL_ENTRIES)) begin
                    n_state = S_FE_CLR;
                end else if (r_cur == r_fidx) begin
                    n_state = S_FE_UL;
                end else begin
                    n_state = S_FE_WD;
                end
            end
            S_FE_WD: begin
                n_prev   = r_cur;
                n_prev_d = r_e_rd;
                n_cur    = r_e_rd.next;
                n_steps  = r_steps + 1'b1;
                n_state  = S_FE_WK;
            end
            S_FE_UL: begin
                if (r_prev == LNULL) begin
                    w_h_we = 1'b1;
                    w_h_wa = w_fqa;
                    w_h_wd = r_fn;
                end else begin
                    w_e_we = 1'b1;
                    w_e_wa = r_prev[IW-1:0];
                    w_e_wd = '{proc: r_prev_d.proc, queue: r_prev_d.queue, next: r_fn};
                end
                n_state = S_FE_CLR;
            end
            S_FE_CLR: begin
                w_e_we = 1'b1;
                w_e_wa = r_fidx[IW-1:0];
                if (r_ret == RET_RM) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RM_SC;
                end else begin
                    n_state = S_WK_HW;
                end
            end
            S_WK_HW: begin
                n_cur = r_h_rd;
                if (r_have) begin
                    n_have  = 1'b0;
                    n_n     = r_n + 1'b1;
                    n_res   = '{status: ST_OK, woken_valid: 1'b1, woken_proc: r_wp,
                                last: w_last};
                    n_nxt   = w_last ? S_IDLE : S_WK_EN;
                    n_state = S_EMIT;
                end else if (r_h_rd >= LNULL) begin
                    n_res   = '{status: ST_OK, woken_valid: 1'b0, woken_proc: PID_NONE,
                                last: 1'b1};
                    n_nxt   = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_WK_EN;
                end
            end
            S_WK_EN: begin
                n_state = S_WK_ED;
            end
            S_WK_ED: begin
                n_wp   = r_e_rd.proc;
                n_have = 1'b1;
                if (r_e_rd.proc != PID_NONE) begin
                    n_rp    = r_e_rd.proc;
                    n_idx   = '0;
                    n_state = S_RM_SC;
                end else begin
                    n_fidx  = r_cur;
                    n_fq    = r_e_rd.queue;
                    n_fn    = r_e_rd.next;
                    n_ret   = RET_WAKE;
                    n_state = S_FE_HD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nxt    <= n_nxt;
        r_op     <= n_op;
        r_q      <= n_q;
        r_p      <= n_p;
        r_rp     <= n_rp;
        r_wp     <= n_wp;
        r_head   <= n_head;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_prev_d <= n_prev_d;
        r_steps  <= n_steps;
        r_idx    <= n_idx;
        r_fidx   <= n_fidx;
        r_fq     <= n_fq;
        r_fn     <= n_fn;
        r_n      <= n_n;
        r_ret    <= n_ret;
        r_have   <= n_have;
        r_res    <= n_res;
        r_o      <= n_o;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_o.status;
    assign o_rsp.woken_valid = r_o.woken_valid;
    assign o_rsp.woken_proc  = r_o.woken_proc;
    assign o_rsp.last        = r_o.last;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("item accepted while another is in work");

    a_no_proc_without_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.woken_valid) |-> (o_rsp.woken_proc == PID_NONE))
        else $error("woken process on a result without a wake");

    a_wake_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.woken_valid) |-> (o_rsp.status == ST_OK))
        else $error("wake result with bad status");

    a_emit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_req.ready)
        else $error("ready while a result is pending");

endmodule

`default_nettype wire
